FILE: rtl/robust_residual_weight_update_core_macros.svh
// Assertion helpers used by the RTL datapath.
`ifndef ROBUST_RESIDUAL_WEIGHT_UPDATE_CORE_MACROS_SVH
`define ROBUST_RESIDUAL_WEIGHT_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define RRWU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRWU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rrwu_pkg.sv
package rrwu_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam logic [15:0] LOW_RESET    = 16'd384;
  localparam logic [15:0] HIGH_RESET   = 16'd896;
  localparam logic [15:0] REJECT_RESET = 16'd655;

  localparam logic [1:0] CFG_LOW    = 2'd0;
  localparam logic [1:0] CFG_HIGH   = 2'd1;
  localparam logic [1:0] CFG_REJECT = 2'd2;

  localparam logic [1:0] CLS_KEEP   = 2'd0;
  localparam logic [1:0] CLS_REDUCE = 2'd1;
  localparam logic [1:0] CLS_REJECT = 2'd2;

  localparam logic [1:0] DIV_MEAN = 2'd0;
  localparam logic [1:0] DIV_V    = 2'd1;
  localparam logic [1:0] DIV_RAT  = 2'd2;
  localparam logic [1:0] DIV_T    = 2'd3;

  typedef struct packed {
    logic       load;
    logic       div_go;
    logic [1:0] div_op;
    logic       sqrt_go;
    logic       ld_rms;
    logic       ld_s;
    logic       ld_elem;
    logic       ld_v;
    logic       ld_t;
    logic       mul_rej;
    logic       mul1;
    logic       mul2;
    logic       emit;
    logic [1:0] res_op;
  } rrwu_cmd_t;

  typedef struct packed {
    logic set_end;
    logic div_done;
    logic sqrt_done;
    logic rms_zero;
    logic v_below;
    logic v_high;
    logic last_idx;
  } rrwu_status_t;

endpackage

FILE: rtl/rrwu_ram.sv
module rrwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/rrwu_div.sv
module rrwu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quotient,
  output logic        busy,
  output logic        done
);

  logic [63:0] rem;
  logic [63:0] dsr;
  logic [6:0]  cnt;
  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic        ge;

  assign rem_sh = {rem, quotient[63]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[63:0] : rem_sh[63:0];
      quotient <= {quotient[62:0], ge};
    end
  end

endmodule

FILE: rtl/rrwu_sqrt.sv
module rrwu_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] b;
  logic [5:0]  cnt;
  logic        busy;
  logic [63:0] rb;

  assign rb   = r + b;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x <= radicand;
      r <= '0;
      b <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (x >= rb) begin
        x <= x - rb;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

FILE: rtl/rrwu_ctrl.sv
module rrwu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  rrwu_pkg::rrwu_status_t st,
  output rrwu_pkg::rrwu_cmd_t    cmd,
  output logic                  busy
);
  import rrwu_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SUMW  = 5'd1;
  localparam logic [4:0] S_MEAN  = 5'd2;
  localparam logic [4:0] S_MEANW = 5'd3;
  localparam logic [4:0] S_RMSW  = 5'd4;
  localparam logic [4:0] S_RD    = 5'd5;
  localparam logic [4:0] S_RDW   = 5'd6;
  localparam logic [4:0] S_CHK   = 5'd7;
  localparam logic [4:0] S_VW    = 5'd8;
  localparam logic [4:0] S_CMP   = 5'd9;
  localparam logic [4:0] S_REJ   = 5'd10;
  localparam logic [4:0] S_RATW  = 5'd11;
  localparam logic [4:0] S_SW    = 5'd12;
  localparam logic [4:0] S_TW    = 5'd13;
  localparam logic [4:0] S_MUL1  = 5'd14;
  localparam logic [4:0] S_MUL2  = 5'd15;
  localparam logic [4:0] S_EMIT  = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [4:0] adv;

  assign busy = state != S_IDLE;
  assign adv  = st.last_idx ? S_IDLE : S_RD;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (st.set_end) state_next = S_SUMW;
        end
      end
      S_SUMW: state_next = S_MEAN;
      S_MEAN: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DIV_MEAN;
        state_next = S_MEANW;
      end
      S_MEANW: begin
        if (st.div_done) begin
          cmd.sqrt_go = 1'b1;
          state_next  = S_RMSW;
        end
      end
      S_RMSW: begin
        if (st.sqrt_done) begin
          cmd.ld_rms = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: state_next = S_RDW;
      S_RDW: begin
        cmd.ld_elem = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (st.rms_zero) begin
          cmd.emit   = 1'b1;
          cmd.res_op = CLS_KEEP;
          state_next = adv;
        end else begin
          cmd.div_go = 1'b1;
          cmd.div_op = DIV_V;
          state_next = S_VW;
        end
      end
      S_VW: begin
        if (st.div_done) begin
          cmd.ld_v   = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (st.v_below) begin
          cmd.emit   = 1'b1;
          cmd.res_op = CLS_KEEP;
          state_next = adv;
        end else if (st.v_high) begin
          cmd.mul_rej = 1'b1;
          state_next  = S_REJ;
        end else begin
          cmd.div_go = 1'b1;
          cmd.div_op = DIV_RAT;
          state_next = S_RATW;
        end
      end
      S_REJ: begin
        cmd.emit   = 1'b1;
        cmd.res_op = CLS_REJECT;
        state_next = adv;
      end
      S_RATW: begin
        if (st.div_done) begin
          cmd.sqrt_go = 1'b1;
          state_next  = S_SW;
        end
      end
      S_SW: begin
        if (st.sqrt_done) begin
          cmd.ld_s   = 1'b1;
          cmd.div_go = 1'b1;
          cmd.div_op = DIV_T;
          state_next = S_TW;
        end
      end
      S_TW: begin
        if (st.div_done) begin
          cmd.ld_t   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        cmd.res_op = CLS_REDUCE;
        state_next = adv;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/rrwu_datapath.sv
`include "robust_residual_weight_update_core_macros.svh"

module rrwu_datapath #(
  parameter int DEPTH = rrwu_pkg::DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rrwu_pkg::rrwu_cmd_t    cmd,
  output rrwu_pkg::rrwu_status_t st,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic signed [31:0]     residual,
  input  logic [30:0]            weight,
  input  logic                   last_item,
  output logic                   result_valid,
  output logic [30:0]            new_weight,
  output logic [1:0]             weight_class,
  output logic                   last_result
);
  import rrwu_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [15:0]   low_thr;
  logic [15:0]   high_thr;
  logic [15:0]   rej_scale;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic [63:0]   sum;
  logic [63:0]   sq;
  logic          sq_vld;
  logic [64:0]   sum_add;
  logic [31:0]   in_u;
  logic [31:0]   in_mag;
  logic [62:0]   rd_data;
  logic [31:0]   rd_r;
  logic [31:0]   e_mag;
  logic [30:0]   e_w;
  logic [31:0]   rms;
  logic [63:0]   v;
  logic [16:0]   s;
  logic [16:0]   t;
  logic [47:0]   p1;
  logic [63:0]   p2;
  logic [46:0]   prej;
  logic [23:0]   lo24;
  logic [23:0]   hi24;
  logic [63:0]   div_a;
  logic [63:0]   div_b;
  logic [63:0]   div_q;
  logic          div_busy;
  logic          div_done;
  logic [31:0]   sq_root;
  logic          sqrt_done;

  assign in_u    = residual;
  assign in_mag  = in_u[31] ? (~in_u + 32'd1) : in_u;
  assign rd_r    = rd_data[62:31];
  assign lo24    = {low_thr, 8'd0};
  assign hi24    = {high_thr, 8'd0};
  assign sum_add = {1'b0, sum} + {1'b0, sq};

  always_comb begin
    case (cmd.div_op)
      DIV_MEAN: begin
        div_a = sum;
        div_b = 64'(count);
      end
      DIV_V: begin
        div_a = 64'({e_mag, 16'd0});
        div_b = 64'(rms);
      end
      DIV_RAT: begin
        div_a = 64'({lo24, 32'd0});
        div_b = v;
      end
      default: begin
        div_a = 64'({hi24 - v[23:0], 16'd0});
        div_b = 64'(hi24 - lo24);
      end
    endcase
  end

  assign st.set_end   = last_item || (count == CW'(DEPTH - 1));
  assign st.div_done  = div_done;
  assign st.sqrt_done = sqrt_done;
  assign st.rms_zero  = rms == '0;
  assign st.v_below   = v < 64'(lo24);
  assign st.v_high    = v >= 64'(hi24);
  assign st.last_idx  = CW'(idx) == (count - CW'(1));

  rrwu_ram #(
    .WIDTH(63),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.load),
    .wr_addr(count[AW-1:0]),
    .wr_data({in_u, weight}),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  rrwu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (cmd.div_go),
    .dividend(div_a),
    .divisor (div_b),
    .quotient(div_q),
    .busy    (div_busy),
    .done    (div_done)
  );

  rrwu_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .go      (cmd.sqrt_go),
    .radicand(div_q),
    .root    (sq_root),
    .done    (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr   <= LOW_RESET;
      high_thr  <= HIGH_RESET;
      rej_scale <= REJECT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOW:    low_thr   <= cfg_data;
        CFG_HIGH:   high_thr  <= cfg_data;
        CFG_REJECT: rej_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      idx          <= '0;
      sum          <= '0;
      sq_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      sq_vld       <= cmd.load;
      result_valid <= cmd.emit;
      if (cmd.load) begin
        count <= count + CW'(1);
      end
      if (sq_vld) begin
        sum <= sum_add[64] ? '1 : sum_add[63:0];
      end
      if (cmd.emit) begin
        if (st.last_idx) begin
          count <= '0;
          sum   <= '0;
          idx   <= '0;
        end else begin
          idx <= idx + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) sq <= in_mag * in_mag;
    if (cmd.ld_rms) rms <= sq_root;
    if (cmd.ld_elem) begin
      e_mag <= rd_r[31] ? (~rd_r + 32'd1) : rd_r;
      e_w   <= rd_data[30:0];
    end
    if (cmd.ld_v) v <= div_q;
    if (cmd.ld_s) s <= sq_root[16:0];
    if (cmd.ld_t) t <= div_q[16:0];
    if (cmd.mul_rej) prej <= e_w * rej_scale;
    if (cmd.mul1) p1 <= e_w * s;
    if (cmd.mul2) p2 <= p1 * t;
    if (cmd.emit) begin
      weight_class <= cmd.res_op;
      last_result  <= st.last_idx;
      case (cmd.res_op)
        CLS_REDUCE: new_weight <= p2[62:32];
        CLS_REJECT: new_weight <= prej[46:16];
        default:    new_weight <= e_w;
      endcase
    end
  end

  `RRWU_ASSERT_IMPL(a_load_room, cmd.load, count < CW'(DEPTH), "load into full store")
  `RRWU_ASSERT_NEXT(a_set_clear, cmd.emit && st.last_idx, count == '0 && sum == '0, "set not cleared")
  `RRWU_ASSERT_IMPL(a_div_idle, cmd.div_go, !div_busy, "divider restarted while busy")

endmodule

FILE: rtl/robust_residual_weight_update_core.sv
// channel  direction  handshake                    word
// input    in         start & !busy                residual, weight, last_item
// config   in         cfg_valid & cfg_ready        cfg_index, cfg_data
// result   out        result_valid, one cycle      new_weight, weight_class, last_result
//
// Loading takes one cycle per word; busy rises after the last word of a set.
// The RMS is then computed with a 64-step shared divider and a 32-step root.
// Per element: a kept or rejected element takes one divider pass, none at zero RMS;
// a reduced one takes three divider passes and one root pass.
// Reset is synchronous and restores the register defaults; results cannot be stalled.
module robust_residual_weight_update_core #(
  parameter int DEPTH = rrwu_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] residual,
  input  logic [30:0]        weight,
  input  logic               last_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               result_valid,
  output logic [30:0]        new_weight,
  output logic [1:0]         weight_class,
  output logic               last_result
);
  import rrwu_pkg::*;

  rrwu_cmd_t    cmd;
  rrwu_status_t st;
  logic         ctrl_busy;

  assign busy      = ctrl_busy;
  assign cfg_ready = 1'b1;

  rrwu_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (st),
    .cmd  (cmd),
    .busy (ctrl_busy)
  );

  rrwu_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .residual    (residual),
    .weight      (weight),
    .last_item   (last_item),
    .result_valid(result_valid),
    .new_weight  (new_weight),
    .weight_class(weight_class),
    .last_result (last_result)
  );

endmodule
